/* rtl/lkoc_pkg.sv */
// Shared types and constants for the LRU keyed object cache.
// Holds sizes, request codes, request/response words and controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lkoc_pkg;

    // Store geometry
    localparam int CAPACITY        = 64;
    localparam int KEY_BITS        = 32;
    localparam int SLOT_W          = $clog2(CAPACITY);
    localparam int COUNT_W         = $clog2(CAPACITY + 1);
    localparam int CFG_W           = 7;
    localparam int REQ_W           = 3;
    localparam int MAX_ITEMS_RESET = 64;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TOUCH  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FORCE  = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [KEY_BITS-1:0] key;
    } req_word_t;

    typedef struct packed {
        logic                ok;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic [KEY_BITS-1:0] evicted_key;
    } rsp_word_t;

    // Source of the response word
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_HIT   = 2'd1,
        RES_ALLOC = 2'd2
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     search;
        logic     touch;
        logic     remove;
        logic     evict;
        logic     alloc;
        logic     load;
        res_sel_t sel;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic evict_needed;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/lkoc_dpath.sv */
// Datapath of the LRU keyed object cache: key cells with match lines, recency ranks,
// item count, limit register and the response register.
// Depends on lkoc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkoc_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lkoc_pkg::dp_cmd_t             cmd,
    output lkoc_pkg::dp_status_t          status,
    input  logic [lkoc_pkg::KEY_BITS-1:0] req_key,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lkoc_pkg::CFG_W-1:0]    cfg_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output lkoc_pkg::rsp_word_t           rsp
);
    import lkoc_pkg::*;

    // Cell storage
    logic [KEY_BITS-1:0] cell_key_reg [CAPACITY];
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]   rank_reg  [CAPACITY];
    logic [SLOT_W-1:0]   rank_next [CAPACITY];
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [CFG_W-1:0]    max_items_reg;

    // Per-request registers
    logic [KEY_BITS-1:0] key_reg;
    logic                hit_reg;
    logic [SLOT_W-1:0]   hit_slot_reg;
    logic [SLOT_W-1:0]   hit_rank_reg;
    logic                ev_reg;
    logic [KEY_BITS-1:0] ev_key_reg;
    rsp_word_t           rsp_reg, rsp_next;
    logic                rsp_valid_reg;

    // Match and select results
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] oldest_vec;
    logic [SLOT_W-1:0]   hit_slot_comb;
    logic [SLOT_W-1:0]   hit_rank_comb;
    logic [KEY_BITS-1:0] oldest_key;
    logic [SLOT_W-1:0]   free_slot;
    logic [COUNT_W-1:0]  count_dec;
    logic [SLOT_W-1:0]   oldest_rank;
    logic [COUNT_W-1:0]  limit;
    logic                out_free;

    assign cfg_ready = 1'b1;

    // Least recent entry holds rank count - 1
    assign count_dec   = count_reg - COUNT_W'(1);
    assign oldest_rank = count_dec[SLOT_W-1:0];

    // Compare every cell, then fold the one-hot match and oldest lines
    always_comb
    begin
        hit_slot_comb = '0;
        hit_rank_comb = '0;
        oldest_key    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_vec[i]  = valid_reg[i] && (cell_key_reg[i] == key_reg);
            oldest_vec[i] = valid_reg[i] && (rank_reg[i] == oldest_rank);
            if (match_vec[i])
            begin
                hit_slot_comb = hit_slot_comb | SLOT_W'(i);
                hit_rank_comb = hit_rank_comb | rank_reg[i];
            end
            if (oldest_vec[i])
            begin
                oldest_key = oldest_key | cell_key_reg[i];
            end
        end
    end

    // Lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    // Clamp the configured limit to 1..CAPACITY
    always_comb
    begin
        if (max_items_reg == '0)
        begin
            limit = COUNT_W'(1);
        end
        else if (32'(max_items_reg) > 32'(CAPACITY))
        begin
            limit = COUNT_W'(CAPACITY);
        end
        else
        begin
            limit = COUNT_W'(max_items_reg);
        end
    end

    assign out_free            = !rsp_valid_reg || rsp_ready;
    assign status.hit          = |match_vec;
    assign status.evict_needed = (count_reg >= limit);
    assign status.out_free     = out_free;

    // Rank and valid updates, broadcast to all cells
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        if (cmd.touch)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                begin
                    rank_next[i] = rank_reg[i] + SLOT_W'(1);
                end
            end
            rank_next[hit_slot_reg] = '0;
        end
        if (cmd.remove)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] > hit_rank_reg))
                begin
                    rank_next[i] = rank_reg[i] - SLOT_W'(1);
                end
            end
            valid_next[hit_slot_reg] = 1'b0;
            rank_next[hit_slot_reg]  = '0;
            count_next               = count_reg - COUNT_W'(1);
        end
        if (cmd.evict)
        begin
            // Oldest holds the top rank, so no other rank moves
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (oldest_vec[i])
                begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
            end
            count_next = count_reg - COUNT_W'(1);
        end
        if (cmd.alloc)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + SLOT_W'(1);
                end
            end
            valid_next[free_slot] = 1'b1;
            rank_next[free_slot]  = '0;
            count_next            = count_reg + COUNT_W'(1);
        end
    end

    // Select the response word
    always_comb
    begin
        rsp_next = '0;
        case (cmd.sel)
            RES_HIT:
            begin
                rsp_next.ok   = hit_reg;
                rsp_next.slot = hit_slot_reg;
            end
            RES_ALLOC:
            begin
                rsp_next.ok          = 1'b1;
                rsp_next.slot        = free_slot;
                rsp_next.evicted     = ev_reg;
                rsp_next.evicted_key = ev_key_reg;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // Control state: cells, count, limit, response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            max_items_reg <= CFG_W'(MAX_ITEMS_RESET);
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
            if (cfg_valid)
            begin
                max_items_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: keys, request latches, response word
    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            cell_key_reg[free_slot] <= key_reg;
        end
        if (cmd.capture)
        begin
            key_reg    <= req_key;
            ev_reg     <= 1'b0;
            ev_key_reg <= '0;
        end
        if (cmd.search)
        begin
            hit_reg      <= status.hit;
            hit_slot_reg <= hit_slot_comb;
            hit_rank_reg <= hit_rank_comb;
        end
        if (cmd.evict)
        begin
            ev_reg     <= 1'b1;
            ev_key_reg <= oldest_key;
        end
        if (cmd.load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* rtl/lkoc_ctrl.sv */
// Sequencer of the LRU keyed object cache: steps each request through search,
// rank update, eviction and allocation. Depends on lkoc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkoc_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [lkoc_pkg::REQ_W-1:0] req_type,
    output lkoc_pkg::dp_cmd_t          cmd,
    input  lkoc_pkg::dp_status_t       status
);
    import lkoc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SEARCH = 7'b0000010,
        ST_TOUCH  = 7'b0000100,
        ST_REMOVE = 7'b0001000,
        ST_EVICT  = 7'b0010000,
        ST_ALLOC  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [REQ_W-1:0] op_reg, op_next;
    logic             hit_style;

    // Lookup, touch and delete answer with the match result
    assign hit_style = (op_reg == REQ_LOOKUP) || (op_reg == REQ_TOUCH) ||
                       (op_reg == REQ_DELETE);

    assign req_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    op_next     = req_type;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                case (op_reg)
                    REQ_LOOKUP: state_next = ST_DONE;
                    REQ_TOUCH:  state_next = status.hit ? ST_TOUCH  : ST_DONE;
                    REQ_DELETE: state_next = status.hit ? ST_REMOVE : ST_DONE;
                    REQ_INSERT: state_next = status.hit ? ST_TOUCH  : ST_EVICT;
                    REQ_FORCE:  state_next = status.hit ? ST_REMOVE : ST_EVICT;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_TOUCH:
            begin
                cmd.touch  = 1'b1;
                state_next = ST_DONE;
            end
            ST_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = (op_reg == REQ_DELETE) ? ST_DONE : ST_EVICT;
            end
            ST_EVICT:
            begin
                cmd.evict  = status.evict_needed;
                state_next = ST_ALLOC;
            end
            ST_ALLOC:
            begin
                // Hold until the response register frees up
                if (status.out_free)
                begin
                    cmd.alloc  = 1'b1;
                    cmd.load   = 1'b1;
                    cmd.sel    = RES_ALLOC;
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = hit_style ? RES_HIT : RES_ZERO;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= REQ_LOOKUP;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/lru_keyed_object_cache_core.sv */
// Channel   Direction  Word                   Handshake
// req       in         lkoc_pkg::req_word_t   req_valid / req_ready
// rsp       out        lkoc_pkg::rsp_word_t   rsp_valid / rsp_ready
// cfg       in         max_items (7 bits)     cfg_valid / cfg_ready (always ready)
//
// One request at a time; req_ready is high while the sequencer is idle.
// Each request is captured and searched by a parallel match of all keys. Lookup, missed touch
// or delete, and unknown codes then answer. Touch and insert of a present key update ranks;
// delete of a present key removes it. Insert or forced insert of an absent key may evict
// the oldest entry, then allocates; forced insert of a present key removes it, then may evict and allocates.
// A stalled response holds in the output register; the next request is taken meanwhile.
// Reset clears all valid bits, ranks and the count at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lru_keyed_object_cache_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  lkoc_pkg::req_word_t        req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output lkoc_pkg::rsp_word_t        rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lkoc_pkg::CFG_W-1:0] cfg_data
);
    import lkoc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    lkoc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req.req_type),
        .cmd       (cmd),
        .status    (status)
    );

    // Cells and response register
    lkoc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_key   (req.key),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

/* rtl/lkoc_checker.sv */
// Port-level checks for lru_keyed_object_cache_core, attached by bind.
// Depends on lkoc_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none

module lkoc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input lkoc_pkg::rsp_word_t rsp
);
    import lkoc_pkg::*;

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // An accepted word keeps the block busy next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // Failed requests report no slot and no eviction
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> (rsp.slot == '0) && !rsp.evicted)
        else $error("failed response carries slot or eviction");

    // Evicted key is zero without an eviction
    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.evicted |-> (rsp.evicted_key == '0))
        else $error("evicted key set without eviction");

endmodule

bind lru_keyed_object_cache_core lkoc_checker u_checker (.*);

`default_nettype wire
